// ===== hdl/assert_macros.svh =====
// Assertion macros used by the parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/nsp_pkg.sv =====
// Types, constants and helper functions of the NMEA sentence parser.
package nsp_pkg;

    localparam int MAX_LEN    = 128;
    localparam int MAX_FIELDS = 32;

    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int FIELD_W = $clog2(MAX_FIELDS);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam int N_TALKERS   = 2;
    localparam int N_SENTENCES = 4;

    localparam logic [7:0] TALKER_TXT [N_TALKERS][2] = '{
        '{8'h49, 8'h4F},            // IO
        '{8'h50, 8'h43}             // PC
    };
    localparam logic [7:0] SENTENCE_TXT [N_SENTENCES][3] = '{
        '{8'h52, 8'h57, 8'h53},     // RWS
        '{8'h52, 8'h52, 8'h53},     // RRS
        '{8'h52, 8'h49, 8'h50},     // RIP
        '{8'h41, 8'h49, 8'h50}      // AIP
    };

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_FIELDS    = 3'd1,
        ST_BAD_SUM      = 3'd2,
        ST_BAD_TALKER   = 3'd3,
        ST_BAD_SENTENCE = 3'd4,
        ST_OVERFLOW     = 3'd5
    } status_t;

    typedef struct packed {
        logic                   hunting;
        logic                   cr_seen;
        logic [LEN_W-1:0]       byte_count;
        logic [FIELD_W-1:0]     field_index;
        logic                   in_checksum;
        logic [1:0]             hex_digits;
        logic                   hex_done;
        logic [7:0]             received_sum;
        logic [7:0]             running_xor;
        logic [2:0]             address_pos;
        logic [N_TALKERS-1:0]   talker_hits;
        logic [N_SENTENCES-1:0] sentence_hits;
        logic                   overflowed;
    } parse_state_t;

    typedef struct packed {
        logic       valid;
        logic       is_end;
        logic [4:0] field_number;
        logic [7:0] data_byte;
        status_t    status;
        logic       talker_id;
        logic [1:0] sentence_id;
        logic [4:0] field_count;
        logic       had_checksum;
    } result_t;

    function automatic parse_state_t start_state(input logic hunt);
        parse_state_t s;
        s               = '0;
        s.hunting       = hunt;
        s.talker_hits   = '1;
        s.sentence_hits = '1;
        return s;
    endfunction

    // {is_hex, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

// ===== hdl/nmea_sentence_parser.sv =====
// Top level of the NMEA sentence parser: input register, parse state, result register.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_ready  rx_byte
//  out      output     out_valid/out_ready  is_end field_number data_byte status
//                                           talker_id sentence_id field_count had_checksum
//
// One byte per cycle while the result is not stalled; a byte that yields a result
// goes from the input register via the one-pass state update to the result register.
// rst_n clears the valid flags and returns the parse state to hunting for '$'.
// A stalled result holds the pipe; in_ready stays high while the input register
// can drain.
`include "assert_macros.svh"

module nmea_sentence_parser
    import nsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_end,
    output logic [4:0] field_number,
    output logic [7:0] data_byte,
    output logic [2:0] status,
    output logic       talker_id,
    output logic [1:0] sentence_id,
    output logic [4:0] field_count,
    output logic       had_checksum
);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t step_state;
    result_t      step_res;
    result_t      out_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         advance;

    nsp_step u_step (
        .rx_byte (in_byte_reg),
        .cur     (state_reg),
        .nxt     (step_state),
        .res     (step_res)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = in_valid;
        state_next = advance ? step_state : state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (advance && step_res.valid)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= start_state(1'b1);
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_byte_reg <= rx_byte;
        if (advance && step_res.valid)
            out_reg <= step_res;
    end

    assign out_valid    = out_valid_reg;
    assign is_end       = out_reg.is_end;
    assign field_number = out_reg.field_number;
    assign data_byte    = out_reg.data_byte;
    assign status       = out_reg.status;
    assign talker_id    = out_reg.talker_id;
    assign sentence_id  = out_reg.sentence_id;
    assign field_count  = out_reg.field_count;
    assign had_checksum = out_reg.had_checksum;

    `ASSERT_NXT(a_end_rehunts, advance && step_res.valid && step_res.is_end, state_reg.hunting)
    `ASSERT_IMP(a_payload_clean, out_valid && !is_end, status == ST_OK && field_count == 5'd0)
    `ASSERT_IMP(a_end_clean, out_valid && is_end, data_byte == 8'd0 && field_number == 5'd0)
    `ASSERT_IMP(a_stall_only, !in_ready, in_valid_reg && out_valid_reg && !out_ready)

endmodule

// ===== hdl/nsp_step.sv =====
// Per-byte next-state and result logic of the sentence parser.
module nsp_step
    import nsp_pkg::*;
(
    input  logic [7:0]   rx_byte,
    input  parse_state_t cur,
    output parse_state_t nxt,
    output result_t      res
);

    logic [4:0] hex;
    logic       t_ok;
    logic       s_ok;
    logic       tid;
    logic [1:0] sid;
    logic [1:0] spos;
    status_t    st;

    assign hex  = hex_value(rx_byte);
    assign spos = 2'(cur.address_pos - 3'd2);

    always_comb
    begin
        t_ok = (cur.address_pos >= 3'd2) && (cur.talker_hits != '0);
        s_ok = (cur.address_pos >= 3'd5) && (cur.sentence_hits != '0);
        tid  = t_ok && !cur.talker_hits[0];
        sid  = '0;
        if (s_ok)
        begin
            for (int k = N_SENTENCES - 1; k >= 0; k--)
                if (cur.sentence_hits[k])
                    sid = 2'(k);
        end
        if (cur.overflowed)
            st = ST_OVERFLOW;
        else if (cur.field_index == '0 && !cur.in_checksum)
            st = ST_NO_FIELDS;
        else if (cur.in_checksum &&
                 (cur.hex_digits == 2'd0 || cur.received_sum != cur.running_xor))
            st = ST_BAD_SUM;
        else if (!t_ok)
            st = ST_BAD_TALKER;
        else if (!s_ok)
            st = ST_BAD_SENTENCE;
        else
            st = ST_OK;
    end

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (rx_byte == CH_DOLLAR)
            nxt = start_state(1'b0);
        else if (cur.hunting)
            nxt = cur;
        else if (rx_byte == CH_CR)
            nxt.cr_seen = 1'b1;
        else if (rx_byte == CH_LF)
        begin
            if (cur.cr_seen)
            begin
                res.valid        = 1'b1;
                res.is_end       = 1'b1;
                res.status       = st;
                res.talker_id    = tid;
                res.sentence_id  = sid;
                res.field_count  = 5'(cur.field_index);
                res.had_checksum = cur.in_checksum;
                nxt              = start_state(1'b1);
            end
        end
        else
        begin
            nxt.cr_seen = 1'b0;
            if (cur.overflowed)
                nxt.overflowed = 1'b1;
            else if (cur.byte_count >= LEN_W'(MAX_LEN))
                nxt.overflowed = 1'b1;
            else
            begin
                nxt.byte_count = cur.byte_count + 1'b1;
                if (cur.in_checksum)
                begin
                    if (!cur.hex_done)
                    begin
                        if (!hex[4])
                            nxt.hex_done = 1'b1;
                        else
                        begin
                            nxt.received_sum = {cur.received_sum[3:0], hex[3:0]};
                            if (cur.hex_digits != 2'd3)
                                nxt.hex_digits = cur.hex_digits + 2'd1;
                        end
                    end
                end
                else if (rx_byte == CH_STAR)
                    nxt.in_checksum = 1'b1;
                else
                begin
                    nxt.running_xor = cur.running_xor ^ rx_byte;
                    if (rx_byte == CH_COMMA)
                    begin
                        if (cur.field_index == FIELD_W'(MAX_FIELDS - 1))
                            nxt.overflowed = 1'b1;
                        else
                            nxt.field_index = cur.field_index + 1'b1;
                    end
                    else
                    begin
                        if (cur.field_index == '0)
                        begin
                            if (cur.address_pos < 3'd2)
                            begin
                                for (int i = 0; i < N_TALKERS; i++)
                                    if (TALKER_TXT[i][cur.address_pos[0]] != rx_byte)
                                        nxt.talker_hits[i] = 1'b0;
                            end
                            else if (cur.address_pos < 3'd5)
                            begin
                                for (int i = 0; i < N_SENTENCES; i++)
                                    if (SENTENCE_TXT[i][spos] != rx_byte)
                                        nxt.sentence_hits[i] = 1'b0;
                            end
                            if (cur.address_pos != 3'd7)
                                nxt.address_pos = cur.address_pos + 3'd1;
                        end
                        res.valid        = 1'b1;
                        res.field_number = 5'(cur.field_index);
                        res.data_byte    = rx_byte;
                    end
                end
            end
        end
    end

endmodule
